>>> rtl/chunked_binary_search_macros.svh
// ----------------------------------------------------------------------------
// chunked_binary_search_macros.svh
// Assertion macros for the chunked binary search block.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BINARY_SEARCH_MACROS_SVH
`define CHUNKED_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

`define CBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define CBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CBS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define CBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Types and codes shared by the chunked binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

	localparam logic REG_ARRAY_LENGTH = 1'b0;
	localparam logic REG_CHUNK_COUNT  = 1'b1;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	localparam int VALUE_W  = 32;
	localparam int ADDR_W   = 10;
	localparam int LENGTH_W = 11;
	localparam int CHUNKS_W = 5;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_CHUNK = 6'b000100,
		S_READ  = 6'b001000,
		S_CMP   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

>>> rtl/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/chunked_binary_search.sv
// ----------------------------------------------------------------------------
// chunked_binary_search
// Sorted element store with a chunked binary search over its first entries.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one element; it gives no result. A search word
// (func 1) splits the first array_length entries (at most STORE_DEPTH) into
// chunk_count chunks (0 taken as 1, at most MAX_CHUNKS), binary searches each
// in turn and returns the index found in the last chunk that matched, or
// position 0 on a miss. A serial divider first finds the chunk size; then each
// chunk is walked, and each probe reads the single store port, whose read data
// is registered, before the compare. A chunk of n elements takes at most
// floor(log2 n)+1 probes. The result then moves to the output register. The
// block takes one word at a time; a result may wait on out_stall while the
// next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chunked_binary_search_macros.svh"

module chunked_binary_search
	import cbs_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_CHUNKS  = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [LENGTH_W-1:0]        cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [ADDR_W-1:0]          address,
	input  wire logic signed [VALUE_W-1:0]  value,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            found,
	output logic [ADDR_W-1:0]               position
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int LW  = $clog2(STORE_DEPTH + 1);
	localparam int CW  = $clog2(MAX_CHUNKS + 1);
	localparam int DCW = $clog2(LW);

	state_t state_q;

	logic [LENGTH_W-1:0]       array_length_q;
	logic [CHUNKS_W-1:0]       chunk_count_q;
	logic signed [VALUE_W-1:0] target_q;
	logic [LW-1:0]             num_q;
	logic [CW-1:0]             rem_q;
	logic [CW-1:0]             w_q;
	logic [CW-1:0]             t_q;
	logic [DCW-1:0]            div_cnt_q;
	logic [LW-1:0]             start_q;
	logic [LW-1:0]             lo_q;
	logic [LW-1:0]             end_q;
	logic [LW-1:0]             mid_q;
	logic                      found_q;
	logic [LW-1:0]             pos_q;
	logic                      out_valid_q;
	logic                      out_found_q;
	logic [ADDR_W-1:0]         out_position_q;

	logic                      in_accept;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [VALUE_W-1:0]        ram_rdata;
	logic [LW-1:0]             len_sat;
	logic [CW-1:0]             w_sat;
	logic [CW:0]               trial;
	logic [CW:0]               trial_diff;
	logic                      trial_ge;
	logic [CW-1:0]             rem_next;
	logic                      extra_bit;
	logic [LW-1:0]             size_c;
	logic [LW-1:0]             end_c;
	logic [LW-1:0]             mid_c;
	logic                      elem_gt;
	logic                      elem_lt;
	logic [LW-1:0]             lo_n;
	logic [LW-1:0]             end_n;
	logic                      out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign ram_we    = in_accept && (func == FUNC_LOAD) &&
	                   ({22'b0, address} < 32'(STORE_DEPTH));
	assign ram_waddr = AW'(address);

	// saturated length and chunk count
	assign len_sat = ({21'b0, array_length_q} > 32'(STORE_DEPTH)) ?
	                 LW'(STORE_DEPTH) : LW'(array_length_q);
	assign w_sat   = (chunk_count_q == '0) ? CW'(1) :
	                 (({27'b0, chunk_count_q} > 32'(MAX_CHUNKS)) ?
	                  CW'(MAX_CHUNKS) : CW'(chunk_count_q));

	// restoring divider step, quotient shifts into num_q
	assign trial      = {rem_q, num_q[LW-1]};
	assign trial_ge   = (trial >= {1'b0, w_q});
	assign trial_diff = trial - {1'b0, w_q};
	assign rem_next   = trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];

	// chunk bounds, exclusive end
	assign extra_bit = (t_q < rem_q);
	assign size_c    = num_q + LW'(extra_bit);
	assign end_c     = start_q + size_c;

	assign mid_c = lo_q + ((end_q - lo_q - LW'(1)) >> 1);

	assign elem_gt = ($signed(ram_rdata) > target_q);
	assign elem_lt = ($signed(ram_rdata) < target_q);
	assign lo_n    = elem_lt ? (mid_q + LW'(1)) : lo_q;
	assign end_n   = elem_gt ? mid_q : end_q;

	cbs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.raddr(mid_c[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= '0;
			chunk_count_q  <= CHUNKS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARRAY_LENGTH: array_length_q <= cfg_data;
				REG_CHUNK_COUNT:  chunk_count_q  <= cfg_data[CHUNKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == S_DONE) && out_free) ||
			               (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && (func == FUNC_SEARCH)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_CHUNK;
					end
				end
				S_CHUNK: begin
					if (t_q == w_q) begin
						state_q <= S_DONE;
					end else if (size_c != '0) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!elem_gt && !elem_lt) begin
						state_q <= S_CHUNK;
					end else if (lo_n < end_n) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_CHUNK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				target_q  <= value;
				num_q     <= len_sat;
				rem_q     <= '0;
				w_q       <= w_sat;
				t_q       <= '0;
				div_cnt_q <= DCW'(LW - 1);
				start_q   <= '0;
				found_q   <= 1'b0;
				pos_q     <= '0;
			end
			S_DIV: begin
				num_q     <= {num_q[LW-2:0], trial_ge};
				rem_q     <= rem_next;
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			S_CHUNK: begin
				if (t_q != w_q) begin
					lo_q    <= start_q;
					end_q   <= end_c;
					start_q <= end_c;
					t_q     <= t_q + CW'(1);
				end
			end
			S_READ: begin
				mid_q <= mid_c;
			end
			S_CMP: begin
				lo_q  <= lo_n;
				end_q <= end_n;
				if (!elem_gt && !elem_lt) begin
					found_q <= 1'b1;
					pos_q   <= mid_q;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_found_q    <= found_q;
					out_position_q <= ADDR_W'(pos_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign position  = out_position_q;

	`CBS_ASSERT_IMP(a_probe_in_range, clk, arst_n, state_q == S_READ, lo_q < end_q)
	`CBS_ASSERT_IMP(a_mid_in_range, clk, arst_n, state_q == S_CMP,
		(mid_q >= lo_q) && (mid_q < end_q) && (end_q <= start_q))
	`CBS_ASSERT_IMP(a_chunk_count, clk, arst_n, state_q == S_CHUNK, t_q <= w_q)
	`CBS_ASSERT_IMP(a_miss_pos_zero, clk, arst_n, out_valid_q && !out_found_q,
		out_position_q == '0)
	`CBS_ASSERT_NXT(a_done_holds, clk, arst_n, (state_q == S_DONE) && !out_free,
		state_q == S_DONE)

endmodule

`default_nettype wire

>>> sim/tb_chunked_binary_search.sv
// ----------------------------------------------------------------------------
// tb_chunked_binary_search
// Self-checking testbench for the chunked binary search block.
// ----------------------------------------------------------------------------
// Load and search words go in over a valid/stall channel. Each accepted load
// updates a local copy of the element store. Each accepted search is answered
// by a local model of the chunked search, and the answer is queued. Every
// result word is compared in order against the queued answers. The register
// settings change only while the block is idle. The store is filled before
// any search can read past the entries that have been written. The tests are
// directed extremes, a full-store pass, output hold-off, a sender pause, and
// random phases of sorted loads with searches and some out-of-order loads.
// ----------------------------------------------------------------------------
module tb_chunked_binary_search;
	import cbs_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int MAX_CHUNKS   = 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 120;
	localparam int MAX_PRINTS   = 100;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic                       cfg_index;
	logic [LENGTH_W-1:0]        cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       func;
	logic [ADDR_W-1:0]          address;
	logic signed [VALUE_W-1:0]  value;
	logic                       out_valid;
	logic                       out_stall;
	logic                       found;
	logic [ADDR_W-1:0]          position;

	// model state
	logic signed [VALUE_W-1:0]  elem_mem [0:DEPTH-1];
	logic [LENGTH_W-1:0]        array_len_reg;
	logic [CHUNKS_W-1:0]        chunk_count_reg;
	logic [ADDR_W:0]            search_answers [$];   // {found, position}

	int mismatches;
	int items_sent;
	int loads_sent;
	int searches_sent;
	int answers_checked;
	int reg_writes;
	bit idle_on;
	bit hold_req;

	chunked_binary_search #(
		.STORE_DEPTH(DEPTH),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.address  (address),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found    (found),
		.position (position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("run limit reached, %0d answers still pending", search_answers.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int eff_len();
		return (array_len_reg > DEPTH) ? DEPTH : int'(array_len_reg);
	endfunction

	function automatic logic [ADDR_W:0] predict_search(input logic signed [VALUE_W-1:0] target);
		int len, w, base, extra, best, lo, hi, mid, hit;
		len = eff_len();
		w = int'(chunk_count_reg);
		if (w < 1) w = 1;
		if (w > MAX_CHUNKS) w = MAX_CHUNKS;
		base = len / w;
		extra = len % w;
		best = -1;
		for (int t = 0; t < w; t++) begin
			lo = t * base + ((t < extra) ? t : extra);
			hi = lo + base + ((t < extra) ? 1 : 0) - 1;
			hit = -1;
			while (lo <= hi && hit < 0) begin
				mid = (hi - lo) / 2 + lo;
				if (elem_mem[mid] > target) hi = mid - 1;
				else if (elem_mem[mid] < target) lo = mid + 1;
				else hit = mid;
			end
			if (hit > best) best = hit;
		end
		return (best >= 0) ? {1'b1, best[ADDR_W-1:0]} : '0;
	endfunction

	// mostly stored elements, some near misses, some random and extremes
	function automatic logic signed [VALUE_W-1:0] pick_target();
		int roll, len;
		logic signed [VALUE_W-1:0] e;
		roll = $urandom_range(99);
		len = eff_len();
		if (len == 0 || roll >= 70) begin
			if (roll >= 90) begin
				case ($urandom_range(2))
					0: return VAL_MIN;
					1: return VAL_MAX;
					default: return '0;
				endcase
			end
			return $urandom();
		end
		e = elem_mem[$urandom_range(len - 1)];
		if (roll < 55) return e;
		return $urandom_range(1) ? e + 1 : e - 1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic f, input logic [ADDR_W-1:0] a,
			input logic signed [VALUE_W-1:0] v);
		if (idle_on && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f == FUNC_LOAD) begin
			elem_mem[a] = v;
			loads_sent++;
		end else begin
			search_answers.push_back(predict_search(v));
			searches_sent++;
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic load_word(input int a, input logic signed [VALUE_W-1:0] v);
		send_word(FUNC_LOAD, a[ADDR_W-1:0], v);
	endtask

	task automatic search_for(input logic signed [VALUE_W-1:0] target);
		send_word(FUNC_SEARCH, ADDR_W'($urandom()), target);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (search_answers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [LENGTH_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ARRAY_LENGTH) array_len_reg = data;
		else chunk_count_reg = data[CHUNKS_W-1:0];
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [LENGTH_W-1:0] len, input logic [LENGTH_W-1:0] chunks);
		wait_idle();
		write_reg(REG_ARRAY_LENGTH, len);
		write_reg(REG_CHUNK_COUNT, chunks);
	endtask

	// register defaults: empty array, nothing can match
	task automatic test_reset_defaults();
		search_for('0);
		search_for(VAL_MIN);
	endtask

	// small array with extremes and duplicates, chunk counts from 0 to 31
	task automatic test_directed();
		load_word(0, VAL_MIN);
		load_word(1, VAL_MIN);
		load_word(2, -5);
		load_word(3, 0);
		load_word(4, 0);
		load_word(5, 0);
		load_word(6, 7);
		load_word(7, VAL_MAX);
		set_regs(11'd8, 11'd1);
		search_for(VAL_MIN);
		search_for(VAL_MAX);
		search_for(0);
		search_for(1);
		set_regs(11'd8, 11'd3);
		search_for(0);
		search_for(7);
		set_regs(11'd8, 11'd16);
		search_for(-5);
		search_for(VAL_MAX);
		set_regs(11'd8, 11'd0);
		search_for(7);
		set_regs(11'd8, 11'd31);
		search_for(VAL_MIN);
		search_for(-6);
	endtask

	// whole store sorted; lengths at and beyond the store size
	task automatic test_full_store();
		longint lv;
		logic signed [VALUE_W-1:0] v;
		for (int i = 0; i < DEPTH; i++) begin
			lv = -64'sd2147483648 + longint'(i) * 4194304 + $urandom_range(4194303);
			v = lv[VALUE_W-1:0];
			if (i > 0 && $urandom_range(9) == 0) v = elem_mem[i - 1];
			if (i == DEPTH - 1) v = VAL_MAX;
			load_word(i, v);
		end
		set_regs(11'd1024, 11'd1);
		repeat (6) search_for(pick_target());
		search_for(VAL_MAX);
		set_regs(11'd2047, 11'd16);
		repeat (6) search_for(pick_target());
		search_for(VAL_MAX);
		set_regs(11'd1025, 11'd5);
		repeat (4) search_for(pick_target());
	endtask

	// results held off for a long stretch while searches keep coming
	task automatic test_output_hold();
		set_regs(11'd1024, 11'd7);
		hold_req = 1'b1;
		repeat (10) search_for(pick_target());
		while (hold_req) @(negedge clk);
	endtask

	// sender stops until every answer is back, then resumes
	task automatic test_sender_pause();
		repeat (5) search_for(pick_target());
		in_valid <= 1'b0;
		while (search_answers.size() != 0) @(negedge clk);
		repeat (5) search_for(pick_target());
	endtask

	// phases: new registers, sorted prefix rewrite, searches with some noise
	task automatic test_random_phases();
		int stop_at, phase, n, span, chunks;
		longint lv;
		stop_at = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < stop_at) begin
			idle_on = (phase != 0);
			chunks = ($urandom_range(9) < 3) ? $urandom_range(2047) : $urandom_range(1, MAX_CHUNKS);
			if ($urandom_range(9) == 0) begin
				set_regs(LENGTH_W'($urandom_range(1000, 2047)), LENGTH_W'(chunks));
			end else begin
				n = ($urandom_range(9) < 8) ? $urandom_range(1, 48) : $urandom_range(49, 200);
				case ($urandom_range(2))
					0: span = 3;
					1: span = 1000;
					default: span = 1 << 24;
				endcase
				lv = longint'($signed($urandom()));
				if ($urandom_range(3) == 0) lv = -64'sd2147483648;
				set_regs(LENGTH_W'(n), LENGTH_W'(chunks));
				for (int i = 0; i < n; i++) begin
					if (lv > 64'sd2147483647) lv = 64'sd2147483647;
					load_word(i, lv[VALUE_W-1:0]);
					lv += $urandom_range(span);
				end
			end
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(9) == 0) load_word($urandom_range(DEPTH - 1), $urandom());
				else search_for(pick_target());
			end
			phase++;
		end
		idle_on = 1'b1;
	endtask

	// receiver: random stall, or a long hold when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 12);
			end
		end
	end

	always @(posedge clk) begin : check_results
		logic [ADDR_W:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (search_answers.size() == 0) begin
				report_mismatch("unexpected result word, position", int'(position), -1);
			end else begin
				want = search_answers.pop_front();
				if (found !== want[ADDR_W])
					report_mismatch("found", int'(found), int'(want[ADDR_W]));
				if (position !== want[ADDR_W-1:0])
					report_mismatch("position", int'(position), int'(want[ADDR_W-1:0]));
				answers_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ARRAY_LENGTH;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		address = '0;
		value = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		mismatches = 0;
		items_sent = 0;
		loads_sent = 0;
		searches_sent = 0;
		answers_checked = 0;
		reg_writes = 0;
		array_len_reg = '0;
		chunk_count_reg = 5'd1;
		for (int i = 0; i < DEPTH; i++) elem_mem[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed();
		test_full_store();
		test_output_hold();
		test_sender_pause();
		test_random_phases();

		wait_idle();
		$display("covered %0d loads and %0d searches, %0d answers checked, %0d register writes",
			loads_sent, searches_sent, answers_checked, reg_writes);
		$display("lengths 0 to beyond the store, chunk counts 0 to 31, long output hold");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
